// ===== hw/rtl/rma_pkg.sv =====
// Shared types and constants for the running moving average block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rma_pkg;

    // Width of the window length register and of the fill count
    localparam int CNT_W = 7;
    // Largest window the count can describe
    localparam int LEN_CAP = (1 << CNT_W) - 1;
    // Window length after reset
    localparam logic [CNT_W-1:0] WLEN_RESET = 7'd16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;      // capture the incoming sample word
        logic upd;       // retire oldest sample, write new one, advance slot
        logic div_load;  // load divider from sum and fill count
        logic div_step;  // one restoring divide iteration
        logic out_load;  // capture the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;  // current divide iteration is the final one
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/running_moving_average.sv =====
// Running moving average over a window of recent samples.
//
// Input channel: i_valid / i_sample, stalled by o_stall. One sample word is
// taken when i_valid is high and o_stall is low. Output channel: o_valid /
// o_average / o_filled_count, stalled by i_stall. Every sample gives exactly
// one result word: the window sum divided by the samples held, truncated
// toward zero, and that count. Configuration: i_cfg_valid / i_cfg_data with
// o_cfg_ready; a write sets the window length (0 disables the filter, a
// value above MAX_WINDOW acts as MAX_WINDOW) and restarts the averaging.
//
// Each sample occupies the block until the bit-per-cycle divider has worked
// through the SUM_W-bit sum, and no new sample is taken meanwhile; the result
// word then passes through the done state into the output register. While the
// receiver stalls, the finished word waits in the output register and the
// next sample is still processed; only its final load waits for space.
// Synchronous reset restores a window of 16 with an empty ring; the ring
// memory itself is not cleared, since only written entries are ever read.
// Depends on rma_pkg, rma_ctrl, rma_dp and rma_ram.
`default_nettype none

module running_moving_average
    import rma_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_stall,
    output logic                               o_valid,
    output logic signed      [SAMPLE_BITS-1:0] o_average,
    output logic             [CNT_W-1:0]       o_filled_count,
    input  wire logic                          i_stall,
    input  wire logic                          i_cfg_valid,
    input  wire logic        [CNT_W-1:0]       i_cfg_data,
    output logic                               o_cfg_ready
);

    localparam int LEN_MAX = (MAX_WINDOW < LEN_CAP) ? MAX_WINDOW : LEN_CAP;
    localparam int SLOT_W  = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(LEN_MAX);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    rma_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_MAX     (LEN_MAX),
        .SLOT_W      (SLOT_W),
        .SUM_W       (SUM_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .o_average      (o_average),
        .o_filled_count (o_filled_count)
    );

`ifndef SYNTH
    // A taken sample keeps the input stalled in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after taking a sample");

    // A new result word appears only from a result load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("result valid without a load");

    // Reported count never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_filled_count <= CNT_W'(LEN_MAX)))
        else $error("filled count beyond ring size");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the sample ring; depends on nothing.
`default_nettype none

module rma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rma_ctrl.sv =====
// Sequencing state machine for the running moving average block.
// Depends on rma_pkg for the command and status structs.
`default_nettype none

module rma_ctrl
    import rma_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  wire logic     i_stall,
    output logic          o_cfg_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_LOAD   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    // Output register can take a new word when empty or being drained
    assign w_out_free = !r_out_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until the receiver takes it
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/rma_dp.sv =====
// Datapath: window register, sample ring, running sum, fill count and a
// restoring divider. Depends on rma_pkg and rma_ram.
`default_nettype none

module rma_dp
    import rma_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_MAX     = 64,
    parameter int SLOT_W      = 6,
    parameter int SUM_W       = 22
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_stat                           o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic        [CNT_W-1:0]       i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed      [SAMPLE_BITS-1:0] o_average,
    output logic             [CNT_W-1:0]       o_filled_count
);

    localparam int STEP_W = $clog2(SUM_W);

    logic        [CNT_W-1:0]       r_wlen;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SUM_W-1:0]       r_sum;
    logic        [CNT_W-1:0]       r_fill;
    logic        [SLOT_W-1:0]      r_slot;

    logic        [CNT_W-1:0]       r_rem;
    logic        [SUM_W-1:0]       r_quo;
    logic        [CNT_W-1:0]       r_div;
    logic                          r_neg;
    logic        [STEP_W-1:0]      r_step;

    logic        [CNT_W-1:0]       w_len;
    logic                          w_len_nz;
    logic                          w_full;
    logic        [SLOT_W-1:0]      w_slot;
    logic        [SLOT_W:0]        w_slot_inc;
    logic        [SAMPLE_BITS-1:0] w_rdata;
    logic signed [SUM_W-1:0]       w_drop;
    logic        [CNT_W:0]         w_shift;
    logic                          w_ge;
    logic        [CNT_W:0]         w_diff;
    logic        [SUM_W-1:0]       w_qsigned;

    // Clamp the window to the ring size
    assign w_len    = (r_wlen > CNT_W'(LEN_MAX)) ? CNT_W'(LEN_MAX) : r_wlen;
    assign w_len_nz = (w_len != '0);
    assign w_full   = (r_fill >= w_len);

    // Slot in use, wrapped if it lies beyond the window
    assign w_slot     = ({1'b0, CNT_W'(r_slot)} >= {1'b0, w_len}) ? '0 : r_slot;
    assign w_slot_inc = {1'b0, w_slot} + 1'b1;

    // Sample ring
    rma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LEN_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd && w_len_nz),
        .i_waddr (w_slot),
        .i_wdata (r_sample),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    // Oldest sample leaves the sum only once the window is full
    assign w_drop = w_full ? SUM_W'($signed(w_rdata)) : '0;

    // Capture the sample word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
    end

    // Window register and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_RESET;
            r_sum  <= '0;
            r_fill <= '0;
            r_slot <= '0;
        end else if (i_cfg_we) begin
            r_wlen <= i_cfg_data;
            r_sum  <= '0;
            r_fill <= '0;
            r_slot <= '0;
        end else if (i_cmd.upd && w_len_nz) begin
            r_sum <= r_sum - w_drop + SUM_W'(r_sample);
            if (!w_full) begin
                r_fill <= r_fill + 1'b1;
            end
            if ((CNT_W + 1)'(w_slot_inc) >= {1'b0, w_len}) begin
                r_slot <= '0;
            end else begin
                r_slot <= w_slot_inc[SLOT_W-1:0];
            end
        end
    end

    // One restoring divide iteration on the magnitude
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg  <= r_sum[SUM_W-1];
            r_quo  <= r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
            r_rem  <= '0;
            r_div  <= r_fill;
            r_step <= STEP_W'(SUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], w_ge};
            r_step <= r_step - 1'b1;
        end
    end

    assign o_stat.div_last = (r_step == '0);

    // Restore the sign; an empty window averages to zero
    assign w_qsigned = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_average      <= (r_div == '0) ? '0 : w_qsigned[SAMPLE_BITS-1:0];
            o_filled_count <= r_div;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/moving_average_checker.sv =====
`timescale 1ns / 1ps
// Result checker for running_moving_average: watches the sample, result and window-length
// channels, predicts each result word and compares it field by field.
// Depends on rma_pkg for the count width and the window length after reset.

module moving_average_checker
    import rma_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic signed [15:0]      i_sample,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic signed [15:0]      i_average,
    input  wire logic        [CNT_W-1:0] i_filled_count,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic        [CNT_W-1:0] i_cfg_data,
    output int                           o_pending,
    output int                           o_fail_count
);

    typedef struct packed {
        logic signed [15:0] average;
        logic [CNT_W-1:0]   count;
    } t_result;

    t_result            awaited_results [$];
    t_result            oldest;
    logic signed [15:0] recent_samples [MAX_WINDOW];
    logic [CNT_W-1:0]   window_setting;
    int                 window_total;
    int                 held_count;
    int                 next_slot;
    int                 mismatch_count = 0;

    // Window length in use: settings above the ring size act as the ring size
    function automatic int active_length();
        if (window_setting > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(window_setting);
    endfunction

    // Fold one sample into the window and return the average word it yields
    function automatic t_result average_after(input logic signed [15:0] s);
        int      len;
        int      slot;
        int      quotient;
        t_result r;
        len = active_length();
        if (len != 0) begin
            slot = (next_slot >= len) ? 0 : next_slot;
            // retire the oldest sample once the ring is full
            if (held_count >= len) begin
                window_total -= recent_samples[slot];
            end else begin
                held_count++;
            end
            recent_samples[slot] = s;
            window_total += s;
            next_slot = (slot + 1 >= len) ? 0 : slot + 1;
        end
        quotient = (held_count != 0) ? window_total / held_count : 0;
        r.average = quotient[15:0];
        r.count   = held_count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_setting = WLEN_RESET;
            window_total   = 0;
            held_count     = 0;
            next_slot      = 0;
            awaited_results.delete();
        end else begin
            // compare an accepted result word with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none, actual average %0d count %0d",
                             $time, i_average, i_filled_count);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_average !== oldest.average) begin
                        mismatch_count++;
                        $display("%0t: average mismatch, expected %0d, actual %0d",
                                 $time, oldest.average, i_average);
                    end
                    if (i_filled_count !== oldest.count) begin
                        mismatch_count++;
                        $display("%0t: filled count mismatch, expected %0d, actual %0d",
                                 $time, oldest.count, i_filled_count);
                    end
                end
            end
            // restart the averaging on a window-length write
            if (i_cfg_valid && i_cfg_ready) begin
                window_setting = i_cfg_data;
                window_total   = 0;
                held_count     = 0;
                next_slot      = 0;
            end
            // predict the word for an accepted sample
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(average_after(i_sample));
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ===== tb/sv/running_moving_average_tb.sv =====
`timescale 1ns / 1ps
// Top of the running_moving_average testbench: clock, reset, sample and window-length
// stimulus, receiver back-pressure and the final verdict.
// Depends on rma_pkg, running_moving_average and moving_average_checker.

module running_moving_average_tb;
    import rma_pkg::*;

    localparam int WORD_TARGET = 1150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;
    localparam int RING_SIZE   = 64;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef enum {MIX_UNIFORM, MIX_EXTREMES, MIX_SMALL, MIX_CONSTANT} t_sample_mix;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic signed [15:0]      i_sample;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [15:0]      o_average;
    logic        [CNT_W-1:0] o_filled_count;
    logic                    i_stall;
    logic                    i_cfg_valid;
    logic        [CNT_W-1:0] i_cfg_data;
    logic                    o_cfg_ready;

    int pending_words;
    int fail_count;
    int cycle_count = 0;
    bit idle_enable = 1'b1;
    bit hold_request = 1'b0;

    // Sign boundaries and extremes under the reset window of 16, long enough to wrap
    logic signed [15:0] opening_run [20] = '{
        32767, 32767, -32768, -32768, 0, -1, 1, 21845, -21846, 256,
        -256, 32767, 32767, 32767, -32768, 12345, -12345, 7, -7, -32768
    };

    running_moving_average dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_sample       (i_sample),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_average      (o_average),
        .o_filled_count (o_filled_count),
        .i_stall        (i_stall),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready)
    );

    moving_average_checker #(
        .MAX_WINDOW (RING_SIZE)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_sample       (i_sample),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_average      (o_average),
        .i_filled_count (o_filled_count),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_words),
        .o_fail_count   (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_enable && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Offer one sample word and hold it until taken; maybe idle afterwards
    task automatic send_sample(input logic signed [15:0] s);
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every predicted word to come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    task automatic write_window(input logic [CNT_W-1:0] setting);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Set a window length, then stream random samples of one flavor through it
    task automatic random_phase(input logic [CNT_W-1:0] setting, input int count,
                                input int hold_at, input int pause_at);
        t_sample_mix        mix;
        logic signed [15:0] level;
        logic signed [15:0] value;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            mix = MIX_UNIFORM;
        end else if (pick < 7) begin
            mix = MIX_EXTREMES;
        end else if (pick < 9) begin
            mix = MIX_SMALL;
        end else begin
            mix = MIX_CONSTANT;
        end
        level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        write_window(setting);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_request = 1'b1;
            end
            if (n == pause_at) begin
                drain();
            end
            case (mix)
                MIX_EXTREMES: begin
                    pick = $urandom_range(0, 7);
                    value = (pick == 0) ? 16'sd0 : (pick == 1) ? -16'sd1 :
                            (pick < 5) ? SAMPLE_MAX : SAMPLE_MIN;
                end
                MIX_SMALL: begin
                    value = 16'(int'($urandom_range(0, 32)) - 16);
                end
                MIX_CONSTANT: begin
                    value = ($urandom_range(0, 15) == 0) ? 16'($urandom()) : level;
                end
                default: begin
                    value = 16'($urandom());
                end
            endcase
            send_sample(value);
        end
        drain();
    endtask

    initial begin
        int               words_counted;
        int               length;
        int               count;
        int               pick;
        logic [CNT_W-1:0] setting;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: fill, wrap and retire extremes
        foreach (opening_run[k]) begin
            send_sample(opening_run[k]);
        end
        drain();

        // Disabled window: samples leave the state alone and average to zero
        write_window('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd5);
        drain();

        // Single-sample window: each word echoes its sample
        write_window(7'd1);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        drain();
        words_counted = 24;

        // Register at its top acts as the full ring; long receiver hold after the first 20 samples
        random_phase(7'd127, 140, 20, -1);
        // Full ring with the sender pausing until all words are back
        random_phase(7'd64, 100, -1, 50);
        words_counted += 240;

        while (words_counted < WORD_TARGET) begin
            // calm last stretch with no idling on either side
            if (words_counted > WORD_TARGET - 150) begin
                idle_enable = 1'b0;
            end
            pick = $urandom_range(0, 19);
            case (pick)
                0:       setting = '0;
                1:       setting = 7'd1;
                2:       setting = 7'd64;
                3:       setting = 7'd127;
                4:       setting = 7'($urandom_range(65, 126));
                5, 6:    setting = 7'($urandom_range(2, 4));
                default: setting = 7'($urandom_range(1, 64));
            endcase
            length = (setting > RING_SIZE) ? RING_SIZE : int'(setting);
            count = (length == 0) ? $urandom_range(2, 5) : length + $urandom_range(4, 60);
            random_phase(setting, count, -1, -1);
            if (length != 0) begin
                words_counted += count;
            end
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rma_pkg.sv
hw/rtl/rma_ram.sv
hw/rtl/rma_ctrl.sv
hw/rtl/rma_dp.sv
hw/rtl/running_moving_average.sv
tb/sv/moving_average_checker.sv
tb/sv/running_moving_average_tb.sv
